// File: rtl/core/rsook_pkg.sv
package rsook_pkg;

    // Fixed field widths
    localparam int ADDR_W       = 26;
    localparam int PERIOD_W     = 16;
    localparam int REPEAT_W     = 3;
    localparam int LEN_W        = 22;
    localparam int FRAMES_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Default number of address symbols in a frame
    localparam int ADDRESS_BITS_DEF = 26;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd260;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 3'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 2'd1;

    // Frame types
    localparam logic [1:0] FT_GROUP_SWITCH = 2'd0;
    localparam logic [1:0] FT_UNIT_SWITCH  = 2'd1;
    localparam logic [1:0] FT_UNIT_DIM     = 2'd2;
    localparam logic [1:0] FT_GROUP_DIM    = 2'd3;

    // Item kinds
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Line symbols
    typedef enum logic [2:0] {
        SYM_ZERO,
        SYM_ONE,
        SYM_DIM,
        SYM_START,
        SYM_STOP
    } sym_kind_t;

    // Input item
    typedef struct packed {
        logic              kind;
        logic [1:0]        frame_type;
        logic [ADDR_W-1:0] address;
        logic [3:0]        unit;
        logic              switch_on;
        logic [3:0]        dim_level;
    } rsook_in_t;

    // Result item
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic rejected;
    } rsook_out_t;

    // Latched frame contents
    typedef struct packed {
        logic [1:0]        frame_type;
        logic [ADDR_W-1:0] address;
        logic [3:0]        unit;
        logic              switch_on;
        logic [3:0]        dim_level;
    } rsook_held_t;

    // Current segment as seen by the sequencer
    typedef struct packed {
        sym_kind_t         kind;
        logic [LEN_W-1:0]  seg_len;
        logic              seg_last;
        logic              sym_stop;
    } rsook_seg_t;

endpackage

// File: rtl/core/rsook_cfg_regs.sv
module rsook_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rsook_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsook_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [rsook_pkg::PERIOD_W-1:0]     period_ticks,
    output logic [rsook_pkg::REPEAT_W-1:0]     repeat_exp
);
    import rsook_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [REPEAT_W-1:0] repeat_reg, repeat_next;

    // Register decode; unknown indexes are ignored
    always_comb begin
        period_next = period_reg;
        repeat_next = repeat_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_PERIOD: period_next = cfg_wdata[PERIOD_W-1:0];
                CFG_REPEAT: repeat_next = cfg_wdata[REPEAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            repeat_reg <= REPEAT_RESET;
        end else begin
            period_reg <= period_next;
            repeat_reg <= repeat_next;
        end
    end

    assign period_ticks = period_reg;
    assign repeat_exp   = repeat_reg;

endmodule

// File: rtl/core/rsook_sym_decode.sv
module rsook_sym_decode #(
    parameter int ADDRESS_BITS = rsook_pkg::ADDRESS_BITS_DEF,
    parameter int SYM_W        = $clog2(ADDRESS_BITS + 12)
) (
    input  rsook_pkg::rsook_held_t             held,
    input  logic [SYM_W-1:0]                   sym_idx,
    input  logic [1:0]                         seg_idx,
    input  logic [rsook_pkg::PERIOD_W-1:0]     period_ticks,
    output rsook_pkg::rsook_seg_t              seg
);
    import rsook_pkg::*;

    localparam logic [SYM_W-1:0] A_SYM = SYM_W'(ADDRESS_BITS);

    logic                dim_frame;
    logic [SYM_W-1:0]    stop_sym;
    logic [SYM_W-1:0]    addr_pos;
    logic [ADDR_W-1:0]   addr_shift;
    logic [SYM_W-1:0]    unit_off;
    logic [SYM_W-1:0]    dim_off;
    sym_kind_t           kind;
    logic [LEN_W-1:0]    t_len;
    logic [LEN_W-1:0]    start_len;
    logic [LEN_W-1:0]    stop_len;
    logic [LEN_W-1:0]    long_len;

    assign dim_frame  = (held.frame_type == FT_UNIT_DIM) || (held.frame_type == FT_GROUP_DIM);
    assign stop_sym   = A_SYM + (dim_frame ? SYM_W'(11) : SYM_W'(7));
    assign addr_pos   = A_SYM - sym_idx;
    // bits above the address field shift out as zero
    assign addr_shift = held.address >> addr_pos;
    assign unit_off   = A_SYM + SYM_W'(6) - sym_idx;
    assign dim_off    = A_SYM + SYM_W'(10) - sym_idx;

    // Symbol at the current position of the frame
    always_comb begin
        if (sym_idx == '0) begin
            kind = SYM_START;
        end else if (sym_idx >= stop_sym) begin
            kind = SYM_STOP;
        end else if (sym_idx <= A_SYM) begin
            kind = addr_shift[0] ? SYM_ONE : SYM_ZERO;
        end else if (sym_idx == A_SYM + SYM_W'(1)) begin
            kind = (held.frame_type == FT_GROUP_SWITCH || held.frame_type == FT_GROUP_DIM)
                   ? SYM_ONE : SYM_ZERO;
        end else if (sym_idx == A_SYM + SYM_W'(2)) begin
            if (dim_frame) kind = SYM_DIM;
            else           kind = held.switch_on ? SYM_ONE : SYM_ZERO;
        end else if (sym_idx <= A_SYM + SYM_W'(6)) begin
            kind = held.unit[unit_off[1:0]] ? SYM_ONE : SYM_ZERO;
        end else begin
            kind = held.dim_level[dim_off[1:0]] ? SYM_ONE : SYM_ZERO;
        end
    end

    // Segment lengths as shift-and-add multiples of T
    assign t_len     = LEN_W'(period_ticks);
    assign start_len = (t_len << 3) + (t_len << 1) + (t_len >> 1);
    assign stop_len  = (t_len << 5) + (t_len << 3);
    assign long_len  = (t_len << 2) + t_len;

    always_comb begin
        seg.kind     = kind;
        seg.sym_stop = (kind == SYM_STOP);
        if (kind inside {SYM_START, SYM_STOP}) seg.seg_last = seg_idx[0];
        else                                   seg.seg_last = (seg_idx == 2'd3);
        if (!seg_idx[0]) begin
            seg.seg_len = t_len;
        end else begin
            case (kind)
                SYM_START: seg.seg_len = start_len;
                SYM_STOP:  seg.seg_len = stop_len;
                SYM_DIM:   seg.seg_len = t_len;
                SYM_ONE:   seg.seg_len = (seg_idx == 2'd1) ? long_len : t_len;
                SYM_ZERO:  seg.seg_len = (seg_idx == 2'd1) ? t_len : long_len;
                default:   seg.seg_len = t_len;
            endcase
        end
    end

endmodule

// File: rtl/core/rsook_seq.sv
module rsook_seq #(
    parameter int ADDRESS_BITS = rsook_pkg::ADDRESS_BITS_DEF,
    parameter int SYM_W        = $clog2(ADDRESS_BITS + 12)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               item_en,
    input  rsook_pkg::rsook_in_t               item,
    input  logic [rsook_pkg::REPEAT_W-1:0]     repeat_exp,
    input  rsook_pkg::rsook_seg_t              seg,
    output rsook_pkg::rsook_held_t             held,
    output logic [SYM_W-1:0]                   sym_idx,
    output logic [1:0]                         seg_idx,
    output rsook_pkg::rsook_out_t              result
);
    import rsook_pkg::*;

    logic               sending_reg, sending_next;
    rsook_held_t        held_reg, held_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic [1:0]         seg_reg, seg_next;
    logic [LEN_W-1:0]   tick_reg, tick_next;
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic               level_reg, level_next;
    logic [LEN_W-1:0]   tick_inc;
    logic               line;
    logic               rej;

    assign tick_inc = tick_reg + LEN_W'(1);

    // Command latch and waveform timer
    always_comb begin
        sending_next = sending_reg;
        held_next    = held_reg;
        sym_next     = sym_reg;
        seg_next     = seg_reg;
        tick_next    = tick_reg;
        frames_next  = frames_reg;
        level_next   = level_reg;
        rej          = 1'b0;
        line         = 1'b0;
        if (item.kind == KIND_COMMAND) begin
            if (sending_reg) begin
                rej = 1'b1;
            end else begin
                held_next.frame_type = item.frame_type;
                held_next.address    = item.address;
                held_next.unit       = (item.frame_type == FT_UNIT_SWITCH ||
                                        item.frame_type == FT_UNIT_DIM) ? item.unit : 4'd0;
                held_next.switch_on  = item.switch_on;
                held_next.dim_level  = item.dim_level;
                sym_next     = '0;
                seg_next     = 2'd0;
                tick_next    = '0;
                frames_next  = FRAMES_W'((9'd1 << repeat_exp) - 9'd1);
                sending_next = 1'b1;
                level_next   = 1'b1;
            end
            line = level_next;
        end else if (sending_reg) begin
            line = level_reg;
            if (tick_inc < seg.seg_len) begin
                tick_next = tick_inc;
            end else begin
                tick_next = '0;
                if (!seg.seg_last) begin
                    seg_next   = seg_reg + 2'd1;
                    // odd segments are low
                    level_next = seg_reg[0];
                end else begin
                    seg_next   = 2'd0;
                    level_next = 1'b1;
                    if (!seg.sym_stop) begin
                        sym_next = sym_reg + SYM_W'(1);
                    end else begin
                        sym_next = '0;
                        if (frames_reg == '0) begin
                            sending_next = 1'b0;
                            level_next   = 1'b0;
                        end else begin
                            frames_next = frames_reg - FRAMES_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg <= 1'b0;
            held_reg    <= '0;
            sym_reg     <= '0;
            seg_reg     <= 2'd0;
            tick_reg    <= '0;
            frames_reg  <= '0;
            level_reg   <= 1'b0;
        end else if (item_en) begin
            sending_reg <= sending_next;
            held_reg    <= held_next;
            sym_reg     <= sym_next;
            seg_reg     <= seg_next;
            tick_reg    <= tick_next;
            frames_reg  <= frames_next;
            level_reg   <= level_next;
        end
    end

    assign held    = held_reg;
    assign sym_idx = sym_reg;
    assign seg_idx = seg_reg;

    assign result.line_level = line;
    assign result.busy_res   = sending_next;
    assign result.rejected   = rej;

endmodule

// File: rtl/core/remote_switch_ook_frame_encoder.sv
// Channel  | Ports                          | Item
// ---------+--------------------------------+-----------------------------------
// input    | s_valid, s_ready, s_data       | base tick or send command
// result   | m_valid, m_ready, m_data       | line level, busy, rejected flag
// config   | cfg_we, cfg_index, cfg_wdata   | period_ticks (0), repeat_exp (1)
//
// One item per cycle while m_ready keeps the result side moving; each item's result passes
// through the input register, then the result register, before it can be taken.
// The frame state updates in one pass per item, set by the segment timer compare.
// Reset is synchronous, active low; it clears state and loads register defaults.
// A stalled result holds in the result register while one more item waits
// in the input register; s_ready drops only when both are full.
module remote_switch_ook_frame_encoder #(
    parameter int ADDRESS_BITS = rsook_pkg::ADDRESS_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rsook_pkg::rsook_in_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rsook_pkg::rsook_out_t              m_data,
    input  logic                               cfg_we,
    input  logic [rsook_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsook_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import rsook_pkg::*;

    localparam int SYM_W = $clog2(ADDRESS_BITS + 12);

    logic                in_valid_reg, in_valid_next;
    rsook_in_t           in_data_reg;
    logic                out_valid_reg, out_valid_next;
    rsook_out_t          out_data_reg;
    logic                advance;
    logic [PERIOD_W-1:0] period_ticks;
    logic [REPEAT_W-1:0] repeat_exp;
    rsook_held_t         held;
    logic [SYM_W-1:0]    sym_idx;
    logic [1:0]          seg_idx;
    rsook_seg_t          seg;
    rsook_out_t          result;

    // Handshake: process the held item when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) in_valid_next = 1'b1;
        else if (advance)       in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (advance)      out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (advance)            out_data_reg <= result;
    end

    rsook_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .period_ticks (period_ticks),
        .repeat_exp   (repeat_exp)
    );

    rsook_sym_decode #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .SYM_W        (SYM_W)
    ) u_decode (
        .held         (held),
        .sym_idx      (sym_idx),
        .seg_idx      (seg_idx),
        .period_ticks (period_ticks),
        .seg          (seg)
    );

    rsook_seq #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .SYM_W        (SYM_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (advance),
        .item       (in_data_reg),
        .repeat_exp (repeat_exp),
        .seg        (seg),
        .held       (held),
        .sym_idx    (sym_idx),
        .seg_idx    (seg_idx),
        .result     (result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: rtl/core/rsook_checker.sv
module rsook_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  rsook_pkg::rsook_in_t               s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  rsook_pkg::rsook_out_t              m_data
);
    import rsook_pkg::*;

    // A dropped command is only possible while frames are in flight
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> m_data.busy_res)
        else $error("rejected result without busy");

    // The line is low whenever no frame is being sent
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.busy_res |-> !m_data.line_level)
        else $error("line high while idle");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A waiting input item holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

    // Reset empties the result slot and opens the input
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending after reset");

endmodule

bind remote_switch_ook_frame_encoder rsook_checker u_rsook_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/sv/tb.sv
module tb;
    import rsook_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int NUM_ADDR       = ADDRESS_BITS_DEF;
    localparam int SETTLE_CYCLES  = 4;      // input register plus result register, with margin
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int MAX_SHOWN      = 10;
    localparam int RESET_CYCLES   = 10;

    // Indexes past the last register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam rsook_out_t OUT_IDLE    = '{line_level: 1'b0, busy_res: 1'b0, rejected: 1'b0};
    localparam rsook_out_t OUT_HIGH    = '{line_level: 1'b1, busy_res: 1'b1, rejected: 1'b0};
    localparam rsook_out_t OUT_DROPPED = '{line_level: 1'b1, busy_res: 1'b1, rejected: 1'b1};

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        rsook_in_t  item;
        bit         pinned;
        rsook_out_t want;
    } stim_row_t;

    typedef struct packed {
        bit         pinned;
        rsook_out_t want;
    } pin_t;

    typedef struct packed {
        int unsigned period_val;
        int unsigned rep_val;
        idle_mode_t  mode;
        int          count;
        bit          stray;
        int          hold;
    } phase_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    rsook_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    rsook_out_t            m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always #HALF_PERIOD aclk = ~aclk;

    remote_switch_ook_frame_encoder #(
        .ADDRESS_BITS(NUM_ADDR)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Transmitter model: registers, latched frame and waveform position
    logic [PERIOD_W-1:0] tx_period = PERIOD_RESET;
    logic [REPEAT_W-1:0] tx_repeat = REPEAT_RESET;
    bit                  tx_busy   = 1'b0;
    rsook_held_t         tx_frame  = '0;
    int unsigned         tx_sym    = 0;
    int unsigned         tx_seg    = 0;
    logic [LEN_W-1:0]    tx_ticks  = '0;
    logic [FRAMES_W-1:0] tx_left   = '0;
    logic                tx_level  = 1'b0;

    rsook_out_t want_q[$];
    pin_t       pin_q[$];

    idle_mode_t mode      = IDLE_NONE;
    int         hold_req  = 0;
    int         hold_left = 0;

    int fail_count     = 0;
    int items_taken    = 0;
    int results_seen   = 0;
    int frames_started = 0;
    int cmds_dropped   = 0;
    int frames_done    = 0;

    function automatic int unsigned last_symbol();
        return NUM_ADDR + (tx_frame.frame_type[1] ? 11 : 7);
    endfunction

    // Symbol sent at a given position of the latched frame
    function automatic sym_kind_t symbol_at(int unsigned s);
        if (s == 0)
            return SYM_START;
        if (s >= last_symbol())
            return SYM_STOP;
        if (s <= NUM_ADDR)
            return tx_frame.address[NUM_ADDR - s] ? SYM_ONE : SYM_ZERO;
        if (s == NUM_ADDR + 1)
            return (tx_frame.frame_type == FT_GROUP_SWITCH ||
                    tx_frame.frame_type == FT_GROUP_DIM) ? SYM_ONE : SYM_ZERO;
        if (s == NUM_ADDR + 2) begin
            if (tx_frame.frame_type[1])
                return SYM_DIM;
            return tx_frame.switch_on ? SYM_ONE : SYM_ZERO;
        end
        if (s <= NUM_ADDR + 6)
            return tx_frame.unit[NUM_ADDR + 6 - s] ? SYM_ONE : SYM_ZERO;
        return tx_frame.dim_level[NUM_ADDR + 10 - s] ? SYM_ONE : SYM_ZERO;
    endfunction

    // Length in ticks of one high or low segment; even segments are high
    function automatic int unsigned segment_ticks(sym_kind_t k, int unsigned seg);
        int unsigned t;
        t = tx_period;
        if (seg % 2 == 0)
            return t;
        case (k)
            SYM_START: return t * 10 + (t >> 1);
            SYM_STOP:  return t * 40;
            SYM_DIM:   return t;
            SYM_ONE:   return (seg == 1) ? t * 5 : t;
            default:   return (seg == 1) ? t : t * 5;
        endcase
    endfunction

    // One base tick of the waveform
    function automatic void advance_line();
        sym_kind_t   k;
        int unsigned segs;
        k        = symbol_at(tx_sym);
        segs     = (k == SYM_START || k == SYM_STOP) ? 2 : 4;
        tx_ticks = tx_ticks + 1'b1;
        if (tx_ticks < segment_ticks(k, tx_seg))
            return;
        tx_ticks = '0;
        tx_seg++;
        if (tx_seg >= segs) begin
            tx_seg = 0;
            tx_sym++;
            if (tx_sym > last_symbol()) begin
                tx_sym = 0;
                if (tx_left == 0) begin
                    tx_busy  = 1'b0;
                    tx_level = 1'b0;
                    frames_done++;
                    return;
                end
                tx_left--;
            end
        end
        tx_level = (tx_seg % 2 == 0);
    endfunction

    function automatic rsook_out_t encode_item(rsook_in_t it);
        rsook_out_t r;
        r = '0;
        if (it.kind == KIND_COMMAND) begin
            if (tx_busy) begin
                r.rejected = 1'b1;
                cmds_dropped++;
            end else begin
                tx_frame.frame_type = it.frame_type;
                tx_frame.address    = it.address;
                // group frames always send unit zero
                tx_frame.unit       = (it.frame_type == FT_UNIT_SWITCH ||
                                       it.frame_type == FT_UNIT_DIM) ? it.unit : 4'd0;
                tx_frame.switch_on  = it.switch_on;
                tx_frame.dim_level  = it.dim_level;
                tx_sym   = 0;
                tx_seg   = 0;
                tx_ticks = '0;
                tx_left  = (8'd1 << tx_repeat) - 8'd1;
                tx_busy  = 1'b1;
                tx_level = 1'b1;
                frames_started++;
            end
            r.line_level = tx_level;
        end else if (tx_busy) begin
            r.line_level = tx_level;
            advance_line();
        end
        r.busy_res = tx_busy;
        return r;
    endfunction

    function automatic stim_row_t make_row(logic kind, logic [1:0] ft,
                                           logic [ADDR_W-1:0] addr, logic [3:0] unit_no,
                                           logic sw, logic [3:0] dim,
                                           bit pinned, rsook_out_t want);
        stim_row_t row;
        row.item.kind       = kind;
        row.item.frame_type = ft;
        row.item.address    = addr;
        row.item.unit       = unit_no;
        row.item.switch_on  = sw;
        row.item.dim_level  = dim;
        row.pinned          = pinned;
        row.want            = want;
        return row;
    endfunction

    function automatic bit src_gap();
        case (mode)
            IDLE_SRC:  return $urandom_range(99) < 83;
            IDLE_BOTH: return $urandom_range(99) < 25;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stall();
        case (mode)
            IDLE_SINK: return $urandom_range(99) < 83;
            IDLE_BOTH: return $urandom_range(99) < 25;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic log_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("ERROR: %s", msg);
    endtask

    // Register write; caller lowers cfg_we after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge aclk);
        if (idx == CFG_PERIOD)
            tx_period = val[PERIOD_W-1:0];
        else if (idx == CFG_REPEAT)
            tx_repeat = val[REPEAT_W-1:0];
    endtask

    // Offer one item, starting and ending on a falling edge
    task automatic offer_item(input stim_row_t row);
        pin_t p;
        p.pinned = row.pinned;
        p.want   = row.want;
        pin_q.push_back(p);
        while (src_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= row.item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Result receiver, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !sink_stall();
        end
    end

    // Check results, then predict for the item accepted at this edge
    always @(posedge aclk) begin
        rsook_out_t want;
        pin_t       pin;
        rsook_out_t guess;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (want_q.size() == 0) begin
                log_fail($sformatf("result %0d at %0t with no item outstanding",
                                   results_seen, $time));
            end else begin
                want = want_q.pop_front();
                if (m_data.line_level !== want.line_level ||
                    m_data.busy_res !== want.busy_res ||
                    m_data.rejected !== want.rejected)
                    log_fail($sformatf({"result %0d at %0t: want line %b busy %b rej %b,",
                                        " got line %b busy %b rej %b"},
                                       results_seen, $time, want.line_level,
                                       want.busy_res, want.rejected, m_data.line_level,
                                       m_data.busy_res, m_data.rejected));
            end
        end
        if (aresetn && s_valid && s_ready) begin
            items_taken++;
            pin   = pin_q.pop_front();
            guess = encode_item(s_data);
            want_q.push_back(pin.pinned ? pin.want : guess);
        end
    end

    initial begin
        stim_row_t  lead[$];
        phase_t     plan [0:5];
        stim_row_t  row;
        logic [63:0] raw;

        // zero period makes every segment one tick, so frames end quickly
        lead.push_back(make_row(KIND_TICK, FT_GROUP_SWITCH, '0, 4'd0, 1'b0, 4'd0,
                                1'b1, OUT_IDLE));
        lead.push_back(make_row(KIND_COMMAND, FT_GROUP_SWITCH, '1, 4'hF, 1'b1, 4'hF,
                                1'b1, OUT_HIGH));
        lead.push_back(make_row(KIND_COMMAND, FT_UNIT_SWITCH, '0, 4'd0, 1'b0, 4'd0,
                                1'b1, OUT_DROPPED));
        lead.push_back(make_row(KIND_COMMAND, FT_UNIT_DIM, '1, 4'hF, 1'b0, 4'hF,
                                1'b1, OUT_DROPPED));
        lead.push_back(make_row(KIND_COMMAND, FT_GROUP_DIM, '0, 4'hF, 1'b1, 4'd0,
                                1'b1, OUT_DROPPED));
        // first tick of the start pulse is still high
        lead.push_back(make_row(KIND_TICK, FT_GROUP_DIM, '1, 4'hF, 1'b1, 4'hF,
                                1'b1, OUT_HIGH));
        for (int k = 0; k < 16; k++)
            lead.push_back(make_row(KIND_TICK, k[1:0], {13{k[0], ~k[0]}}, k[3:0], k[1],
                                    ~k[3:0], 1'b0, OUT_IDLE));

        plan[0] = '{0,     1, IDLE_NONE, 80, 1'b0, 40};
        plan[1] = '{0,     0, IDLE_SRC,  80, 1'b0, 0};
        plan[2] = '{1,     0, IDLE_SINK, 60, 1'b0, 0};
        plan[3] = '{0,     0, IDLE_BOTH, 80, 1'b0, 0};
        plan[4] = '{65535, 7, IDLE_NONE, 40, 1'b0, 0};
        plan[5] = '{0,     3, IDLE_SRC,  40, 1'b1, 0};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(CFG_PERIOD, 0);
        write_reg(CFG_REPEAT, 1);
        cfg_we <= 1'b0;
        foreach (lead[k])
            offer_item(lead[k]);

        foreach (plan[p]) begin
            // registers change only with nothing in flight
            s_valid <= 1'b0;
            while (want_q.size() != 0)
                @(negedge aclk);
            if (plan[p].stray) begin
                write_reg(CFG_SPARE_A, 16'hFFFF);
                write_reg(CFG_SPARE_B, 16'hFFFF);
            end
            write_reg(CFG_PERIOD, plan[p].period_val);
            write_reg(CFG_REPEAT, plan[p].rep_val);
            cfg_we   <= 1'b0;
            mode     = plan[p].mode;
            hold_req = plan[p].hold;
            for (int n = 0; n < plan[p].count; n++) begin
                raw      = {$urandom, $urandom};
                row      = '0;
                row.item = raw[$bits(rsook_in_t)-1:0];
                // start frames promptly when idle, mostly ticks while sending
                row.item.kind = ($urandom_range(tx_busy ? 19 : 2) == 0) ?
                                KIND_COMMAND : KIND_TICK;
                offer_item(row);
            end
        end

        s_valid <= 1'b0;
        while (want_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Covered %0d items and %0d results: %0d frames started, %0d commands dropped",
                 items_taken, results_seen, frames_started, cmds_dropped);
        $display("while busy, %0d frame sequences completed, %0d mismatches.",
                 frames_done, fail_count);
        if (fail_count == 0 && want_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rsook_pkg.sv
rtl/core/rsook_cfg_regs.sv
rtl/core/rsook_sym_decode.sv
rtl/core/rsook_seq.sv
rtl/core/remote_switch_ook_frame_encoder.sv
rtl/core/rsook_checker.sv
tb/sv/tb.sv
